// File: sv/rlst_pkg.sv
// rlst_pkg: sizes, entry and control types, and operation codes of the run-length span table
// used by rlst_cell, rlst_chain, run_length_span_table_unit and the testbench; no other dependencies
`default_nettype none
package rlst_pkg;

   localparam int MAX_RUNS    = 64;
   localparam int LENGTH_BITS = 16;
   localparam int STYLE_BITS  = 8;
   localparam int IDX_BITS    = $clog2(MAX_RUNS);
   localparam int CNT_BITS    = $clog2(MAX_RUNS + 1);

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_FIND   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_PASS,
      ST_MERGE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [STYLE_BITS-1:0]  style;
      logic [LENGTH_BITS-1:0] length;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                pop;
      logic                push;
      logic [IDX_BITS-1:0] wr_idx;
      entry_type           wr_data;
   } chain_ctl_type;

endpackage
`default_nettype wire

// File: sv/run_length_span_table_unit.sv
// run_length_span_table_unit: top level of the run-length span table, sequencer and result register
// depends on rlst_pkg and rlst_chain
//
// the runs live in a chain of slot cells used as a queue; find, remove and insert on a
// non-empty table make one pass that pops each run at the head and pushes the (possibly
// changed) runs back at the tail, so the table ends up in order again. a remove that drops a
// run adds a merge pass over the runs left after the removal. clear, an insert refused for
// overflow, an insert into an empty table, a find or remove on an empty table and a remove of
// zero length make no pass. the pass walks one run per cycle, except while it pushes the runs
// that an insert adds or splits off, so the chain length sets the cost. a new transaction is
// taken while the previous result still waits in the output register
`default_nettype none
module run_length_span_table_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_kind,
   input  wire logic [rlst_pkg::LENGTH_BITS-1:0]   req_text_offset,
   input  wire logic [rlst_pkg::STYLE_BITS-1:0]    req_run_style,
   input  wire logic [rlst_pkg::LENGTH_BITS-1:0]   req_span_length,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_accepted,
   output logic                                    rsp_found_valid,
   output logic [rlst_pkg::STYLE_BITS-1:0]         rsp_found_style,
   output logic [rlst_pkg::LENGTH_BITS-1:0]        rsp_found_length,
   output logic [rlst_pkg::CNT_BITS-1:0]           rsp_runs_in_use,
   output logic [rlst_pkg::LENGTH_BITS-1:0]        rsp_total_text_length
);

   // control state
   rlst_pkg::state_type state_ff, state_in;
   logic [rlst_pkg::CNT_BITS-1:0] q_cnt_ff, q_cnt_in;       // runs physically in the chain
   logic [rlst_pkg::CNT_BITS-1:0] left_ff, left_in;         // pops still due in this pass
   logic [1:0]                    ex_cnt_ff, ex_cnt_in;     // extra runs waiting to be pushed
   logic [rlst_pkg::LENGTH_BITS-1:0] total_ff, total_in;
   logic rsp_valid_ff, rsp_valid_in;

   // transaction context
   rlst_pkg::kind_type kind_ff, kind_in;
   logic [rlst_pkg::LENGTH_BITS-1:0] off_ff, off_in;
   logic [rlst_pkg::STYLE_BITS-1:0]  style_ff, style_in;
   logic [rlst_pkg::LENGTH_BITS-1:0] len_ff, len_in;
   logic [rlst_pkg::LENGTH_BITS-1:0] rem_ff, rem_in;        // still to remove
   logic [rlst_pkg::LENGTH_BITS-1:0] sum_ff, sum_in;        // lengths pushed so far this pass
   logic done_ff, done_in;                                  // action taken, rest passes through
   logic acc_ff, acc_in;
   logic dropped_ff, dropped_in;
   logic fv_ff, fv_in;
   logic pend_v_ff, pend_v_in;
   rlst_pkg::entry_type ex0_ff, ex0_in, ex1_ff, ex1_in;
   rlst_pkg::entry_type found_ff, found_in;
   rlst_pkg::entry_type pend_ff, pend_in;

   // result register
   logic rsp_acc_ff, rsp_acc_in, rsp_fv_ff, rsp_fv_in;
   rlst_pkg::entry_type rsp_found_ff, rsp_found_in;
   logic [rlst_pkg::CNT_BITS-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [rlst_pkg::LENGTH_BITS-1:0] rsp_total_ff, rsp_total_in;

   // chain access
   rlst_pkg::chain_ctl_type ctl;
   rlst_pkg::entry_type     head;
   rlst_pkg::entry_type     new_run;
   logic pop, push;
   rlst_pkg::entry_type wdata;

   logic req_fire, rsp_load, pass_end;
   logic [rlst_pkg::LENGTH_BITS:0] ovf_sum;
   logic ovf;
   logic empty;

   // per-run arithmetic of the pass
   logic [rlst_pkg::LENGTH_BITS:0]   run_end, cut_end, tail_keep, keep_w;
   logic [rlst_pkg::LENGTH_BITS-1:0] head_keep, keep, cut, into_run;
   logic last, boundary, covers;

   assign req_ready = (state_ff == rlst_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == rlst_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign pass_end  = (ex_cnt_ff == 2'd0) && (left_ff == '0);
   assign ovf_sum   = {1'b0, total_ff} + {1'b0, req_span_length};
   assign ovf       = ovf_sum[rlst_pkg::LENGTH_BITS];
   assign empty     = (q_cnt_ff == '0);
   assign new_run   = '{style: style_ff, length: len_ff};
   assign last      = (left_ff == rlst_pkg::CNT_BITS'(1));

   assign run_end   = {1'b0, sum_ff} + {1'b0, head.length};
   assign cut_end   = {1'b0, off_ff} + {1'b0, rem_ff};
   assign head_keep = (sum_ff < off_ff) ? off_ff - sum_ff : '0;
   assign tail_keep = (cut_end < run_end) ? run_end - cut_end : '0;
   assign keep_w    = {1'b0, head_keep} + tail_keep;
   assign keep      = keep_w[rlst_pkg::LENGTH_BITS-1:0];
   assign cut       = head.length - keep;
   assign into_run  = off_ff - sum_ff;
   assign boundary  = (sum_ff == off_ff) || (run_end == {1'b0, off_ff});
   assign covers    = run_end > {1'b0, off_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlst_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (rlst_pkg::kind_type'(req_kind))
                  rlst_pkg::KIND_INSERT:
                     state_in = ovf ? rlst_pkg::ST_FINISH :
                                empty ? rlst_pkg::ST_APPEND : rlst_pkg::ST_PASS;
                  rlst_pkg::KIND_REMOVE:
                     state_in = (empty || (req_span_length == '0)) ?
                                rlst_pkg::ST_FINISH : rlst_pkg::ST_PASS;
                  rlst_pkg::KIND_FIND:
                     state_in = empty ? rlst_pkg::ST_FINISH : rlst_pkg::ST_PASS;
                  default:
                     state_in = rlst_pkg::ST_FINISH;
               endcase
            end
         end
         rlst_pkg::ST_APPEND: state_in = rlst_pkg::ST_FINISH;
         rlst_pkg::ST_PASS: begin
            if (pass_end) begin
               state_in = ((kind_ff == rlst_pkg::KIND_REMOVE) && dropped_ff) ?
                          rlst_pkg::ST_MERGE : rlst_pkg::ST_FINISH;
            end
         end
         rlst_pkg::ST_MERGE: begin
            if (left_ff == '0) state_in = rlst_pkg::ST_FINISH;
         end
         rlst_pkg::ST_FINISH: begin
            if (rsp_load) state_in = rlst_pkg::ST_IDLE;
         end
         default: state_in = rlst_pkg::ST_IDLE;
      endcase
   end

   // datapath and chain control
   always_comb begin
      q_cnt_in   = q_cnt_ff;
      left_in    = left_ff;
      ex_cnt_in  = ex_cnt_ff;
      total_in   = total_ff;
      kind_in    = kind_ff;
      off_in     = off_ff;
      style_in   = style_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      sum_in     = sum_ff;
      done_in    = done_ff;
      acc_in     = acc_ff;
      dropped_in = dropped_ff;
      fv_in      = fv_ff;
      pend_v_in  = pend_v_ff;
      ex0_in     = ex0_ff;
      ex1_in     = ex1_ff;
      found_in   = found_ff;
      pend_in    = pend_ff;
      pop        = 1'b0;
      push       = 1'b0;
      wdata      = head;

      unique case (state_ff)
         rlst_pkg::ST_IDLE: begin
            if (req_fire) begin
               kind_in    = rlst_pkg::kind_type'(req_kind);
               off_in     = req_text_offset;
               style_in   = req_run_style;
               len_in     = req_span_length;
               rem_in     = req_span_length;
               sum_in     = '0;
               done_in    = 1'b0;
               acc_in     = 1'b1;
               dropped_in = 1'b0;
               fv_in      = 1'b0;
               ex_cnt_in  = 2'd0;
               left_in    = q_cnt_ff;
               case (rlst_pkg::kind_type'(req_kind))
                  rlst_pkg::KIND_INSERT: begin
                     if (ovf) acc_in = 1'b0;
                  end
                  rlst_pkg::KIND_CLEAR: begin
                     q_cnt_in = '0;
                     total_in = '0;
                  end
                  default: ;
               endcase
            end
         end

         rlst_pkg::ST_APPEND: begin
            push     = 1'b1;
            wdata    = new_run;
            q_cnt_in = q_cnt_ff + rlst_pkg::CNT_BITS'(1);
            total_in = len_ff;
         end

         rlst_pkg::ST_PASS: begin
            if (ex_cnt_ff != 2'd0) begin
               // drain runs added by an insert
               push      = 1'b1;
               wdata     = ex0_ff;
               ex0_in    = ex1_ff;
               ex_cnt_in = ex_cnt_ff - 2'd1;
               q_cnt_in  = q_cnt_ff + rlst_pkg::CNT_BITS'(1);
               sum_in    = sum_ff + ex0_ff.length;
            end else if (left_ff != '0) begin
               pop     = 1'b1;
               push    = 1'b1;
               left_in = left_ff - rlst_pkg::CNT_BITS'(1);
               case (kind_ff)
                  rlst_pkg::KIND_INSERT: begin
                     if (!done_ff) begin
                        if (boundary || covers) begin
                           done_in = 1'b1;
                           if (head.style == style_ff) begin
                              wdata.length = head.length + len_ff;
                           end else if (boundary) begin
                              if (q_cnt_ff >= rlst_pkg::CNT_BITS'(rlst_pkg::MAX_RUNS)) begin
                                 acc_in = 1'b0;
                              end else begin
                                 ex_cnt_in = 2'd1;
                                 // new span goes before the run when the offset is its start
                                 if (sum_ff == off_ff) begin
                                    wdata  = new_run;
                                    ex0_in = head;
                                 end else begin
                                    ex0_in = new_run;
                                 end
                              end
                           end else if (q_cnt_ff >
                                        rlst_pkg::CNT_BITS'(rlst_pkg::MAX_RUNS - 2)) begin
                              acc_in = 1'b0;
                           end else begin
                              // split: head part, new span, tail part
                              wdata.length = into_run;
                              ex0_in       = new_run;
                              ex1_in       = '{style: head.style,
                                               length: head.length - into_run};
                              ex_cnt_in    = 2'd2;
                           end
                        end else if (last) begin
                           // past the end of the text
                           done_in = 1'b1;
                           if (head.style == style_ff) begin
                              wdata.length = head.length + len_ff;
                           end else if (q_cnt_ff >=
                                        rlst_pkg::CNT_BITS'(rlst_pkg::MAX_RUNS)) begin
                              acc_in = 1'b0;
                           end else begin
                              ex0_in    = new_run;
                              ex_cnt_in = 2'd1;
                           end
                        end
                     end
                  end
                  rlst_pkg::KIND_REMOVE: begin
                     if (!done_ff && ((sum_ff == off_ff) || covers)) begin
                        if (keep == '0) begin
                           push       = 1'b0;
                           dropped_in = 1'b1;
                           rem_in     = (rem_ff >= head.length) ? rem_ff - head.length : '0;
                        end else begin
                           wdata.length = keep;
                           rem_in       = (rem_ff >= cut) ? rem_ff - cut : '0;
                           if (rem_ff <= cut) done_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (!fv_ff && (covers || last)) begin
                        fv_in    = 1'b1;
                        found_in = head;
                     end
                  end
               endcase
               if (push) begin
                  sum_in = sum_ff + wdata.length;
               end else begin
                  q_cnt_in = q_cnt_ff - rlst_pkg::CNT_BITS'(1);
               end
            end else begin
               total_in  = sum_ff;
               left_in   = q_cnt_ff;
               pend_v_in = 1'b0;
            end
         end

         rlst_pkg::ST_MERGE: begin
            if (left_ff != '0) begin
               pop     = 1'b1;
               left_in = left_ff - rlst_pkg::CNT_BITS'(1);
               if (pend_v_ff && (pend_ff.style == head.style)) begin
                  pend_in.length = pend_ff.length + head.length;
                  q_cnt_in       = q_cnt_ff - rlst_pkg::CNT_BITS'(1);
               end else begin
                  pend_in   = head;
                  pend_v_in = 1'b1;
                  if (pend_v_ff) begin
                     push  = 1'b1;
                     wdata = pend_ff;
                  end else begin
                     q_cnt_in = q_cnt_ff - rlst_pkg::CNT_BITS'(1);
                  end
               end
            end else if (pend_v_ff) begin
               push      = 1'b1;
               wdata     = pend_ff;
               pend_v_in = 1'b0;
               q_cnt_in  = q_cnt_ff + rlst_pkg::CNT_BITS'(1);
            end
         end

         rlst_pkg::ST_FINISH: ;
         default: ;
      endcase
   end

   // write lands behind the last run, one slot lower when the head leaves this cycle
   always_comb begin
      ctl.pop     = pop;
      ctl.push    = push;
      ctl.wr_data = wdata;
      ctl.wr_idx  = pop ? rlst_pkg::IDX_BITS'(q_cnt_ff - rlst_pkg::CNT_BITS'(1))
                        : rlst_pkg::IDX_BITS'(q_cnt_ff);
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_fv_in    = rsp_fv_ff;
      rsp_found_in = rsp_found_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_total_in = rsp_total_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_acc_in   = acc_ff;
         rsp_fv_in    = fv_ff;
         rsp_found_in = fv_ff ? found_ff : '0;
         rsp_cnt_in   = q_cnt_ff;
         rsp_total_in = total_ff;
      end
   end

   rlst_chain u_chain (
      .clock (clock),
      .ctl   (ctl),
      .head  (head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlst_pkg::ST_IDLE;
         q_cnt_ff     <= '0;
         left_ff      <= '0;
         ex_cnt_ff    <= 2'd0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_cnt_ff     <= q_cnt_in;
         left_ff      <= left_in;
         ex_cnt_ff    <= ex_cnt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      off_ff       <= off_in;
      style_ff     <= style_in;
      len_ff       <= len_in;
      rem_ff       <= rem_in;
      sum_ff       <= sum_in;
      done_ff      <= done_in;
      acc_ff       <= acc_in;
      dropped_ff   <= dropped_in;
      fv_ff        <= fv_in;
      pend_v_ff    <= pend_v_in;
      ex0_ff       <= ex0_in;
      ex1_ff       <= ex1_in;
      found_ff     <= found_in;
      pend_ff      <= pend_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_fv_ff    <= rsp_fv_in;
      rsp_found_ff <= rsp_found_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accepted          = rsp_acc_ff;
   assign rsp_found_valid       = rsp_fv_ff;
   assign rsp_found_style       = rsp_found_ff.style;
   assign rsp_found_length      = rsp_found_ff.length;
   assign rsp_runs_in_use       = rsp_cnt_ff;
   assign rsp_total_text_length = rsp_total_ff;

endmodule
`default_nettype wire

// File: sv/rlst_cell.sv
// rlst_cell: one run slot of the table; shifts toward the head on pop, loads on a matching write
// depends on rlst_pkg
`default_nettype none
module rlst_cell (
   input  wire logic                         clock,
   input  wire rlst_pkg::chain_ctl_type      ctl,
   input  wire logic [rlst_pkg::IDX_BITS-1:0] cell_idx,
   input  wire rlst_pkg::entry_type          from_next,
   output rlst_pkg::entry_type               held
);

   rlst_pkg::entry_type entry_ff;
   rlst_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push && (ctl.wr_idx == cell_idx)) begin
         entry_in = ctl.wr_data;
      end else if (ctl.pop) begin
         entry_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign held = entry_ff;

endmodule
`default_nettype wire

// File: sv/rlst_chain.sv
// rlst_chain: row of rlst_cell slots forming a queue whose head sits in slot zero
// depends on rlst_pkg and rlst_cell
`default_nettype none
module rlst_chain (
   input  wire logic                    clock,
   input  wire rlst_pkg::chain_ctl_type ctl,
   output rlst_pkg::entry_type          head
);

   rlst_pkg::entry_type held [rlst_pkg::MAX_RUNS];

   for (genvar g = 0; g < rlst_pkg::MAX_RUNS; g++) begin : g_cell
      rlst_pkg::entry_type nxt;
      if (g == rlst_pkg::MAX_RUNS - 1) begin : g_last
         // the tail slot only ever gets written, never shifted into
         assign nxt = held[g];
      end else begin : g_mid
         assign nxt = held[g+1];
      end
      rlst_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cell_idx  (rlst_pkg::IDX_BITS'(g)),
         .from_next (nxt),
         .held      (held[g])
      );
   end

   assign head = held[0];

endmodule
`default_nettype wire

// File: tb/sv/tb_run_length_span_table_unit.sv
// tb_run_length_span_table_unit: self-checking testbench for run_length_span_table_unit
// depends on rlst_pkg and the run-length span table rtl; a directed table, then random traffic
`default_nettype none
module tb_run_length_span_table_unit;

   localparam int MAX_RUNS    = rlst_pkg::MAX_RUNS;
   localparam int LENGTH_BITS = rlst_pkg::LENGTH_BITS;
   localparam int STYLE_BITS  = rlst_pkg::STYLE_BITS;
   localparam int CNT_BITS    = rlst_pkg::CNT_BITS;
   localparam int LMAX = (1 << LENGTH_BITS) - 1;

   typedef struct {
      rlst_pkg::kind_type     kind;
      logic [LENGTH_BITS-1:0] off;
      logic [STYLE_BITS-1:0]  style;
      logic [LENGTH_BITS-1:0] len;
      bit                     fixed;   // expected result typed in below
      logic                   acc;
      logic [CNT_BITS-1:0]    runs;
      logic [LENGTH_BITS-1:0] total;
   } stim_row_type;

   typedef struct {
      logic                   acc;
      logic                   fv;
      logic [STYLE_BITS-1:0]  fs;
      logic [LENGTH_BITS-1:0] fl;
      logic [CNT_BITS-1:0]    runs;
      logic [LENGTH_BITS-1:0] total;
   } span_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = '0;
   logic [LENGTH_BITS-1:0] req_text_offset = '0;
   logic [STYLE_BITS-1:0] req_run_style = '0;
   logic [LENGTH_BITS-1:0] req_span_length = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_accepted, rsp_found_valid;
   logic [STYLE_BITS-1:0] rsp_found_style;
   logic [LENGTH_BITS-1:0] rsp_found_length;
   logic [CNT_BITS-1:0] rsp_runs_in_use;
   logic [LENGTH_BITS-1:0] rsp_total_text_length;

   run_length_span_table_unit uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the run table
   logic [STYLE_BITS-1:0] shadow_style [MAX_RUNS+2];
   longint unsigned       shadow_len [MAX_RUNS+2];
   int unsigned           shadow_count;

   span_result_type expected_results [$];
   int  fail_count = 0;
   bit  stim_done = 1'b0;

   function automatic longint unsigned table_sum();
      longint unsigned s;
      s = 0;
      for (int i = 0; i < shadow_count; i++) s += shadow_len[i];
      return s;
   endfunction

   function automatic void slot_open(int unsigned pos, logic [STYLE_BITS-1:0] st,
                                     longint unsigned ln);
      for (int k = shadow_count; k > pos; k--) begin
         shadow_style[k] = shadow_style[k-1];
         shadow_len[k]   = shadow_len[k-1];
      end
      shadow_style[pos] = st;
      shadow_len[pos]   = ln;
      shadow_count++;
   endfunction

   function automatic void slot_close(int unsigned pos);
      for (int k = pos; k + 1 < shadow_count; k++) begin
         shadow_style[k] = shadow_style[k+1];
         shadow_len[k]   = shadow_len[k+1];
      end
      shadow_count--;
   endfunction

   function automatic bit span_insert(longint unsigned off, logic [STYLE_BITS-1:0] st,
                                      longint unsigned ln);
      longint unsigned start, rl, stop;
      start = 0;
      if (table_sum() + ln > LMAX) return 0;
      for (int unsigned i = 0; i < shadow_count; i++) begin
         rl = shadow_len[i];
         stop = start + rl;
         if (start == off || stop == off) begin
            if (shadow_style[i] == st) begin
               shadow_len[i] = rl + ln;
               return 1;
            end
            if (shadow_count >= MAX_RUNS) return 0;
            slot_open((start != off) ? i + 1 : i, st, ln);
            return 1;
         end
         if (stop > off) begin
            if (shadow_style[i] == st) begin
               shadow_len[i] = rl + ln;
               return 1;
            end
            if (shadow_count + 2 > MAX_RUNS) return 0;
            slot_open(i + 1, st, ln);
            slot_open(i + 2, shadow_style[i], rl - (off - start));
            shadow_len[i] = off - start;
            return 1;
         end
         start = stop;
      end
      if (shadow_count > 0 && shadow_style[shadow_count-1] == st) begin
         shadow_len[shadow_count-1] += ln;
         return 1;
      end
      if (shadow_count >= MAX_RUNS) return 0;
      slot_open(shadow_count, st, ln);
      return 1;
   endfunction

   function automatic void range_remove(longint unsigned off, longint unsigned ln);
      longint unsigned start, rl, keep;
      int unsigned i;
      bit dropped;
      start = 0;
      i = 0;
      dropped = 0;
      if (ln == 0) return;
      while (i < shadow_count) begin
         rl = shadow_len[i];
         if (start == off || start + rl > off) begin
            keep = 0;
            if (start < off) keep += off - start;
            if (off + ln < start + rl) keep += (start + rl) - (off + ln);
            if (keep == 0) begin
               ln = (ln >= rl) ? ln - rl : 0;
               slot_close(i);
               dropped = 1;
               continue;
            end
            ln = (ln >= rl - keep) ? ln - (rl - keep) : 0;
            shadow_len[i] = keep;
            rl = keep;
            if (ln == 0) break;
         end
         start += rl;
         i++;
      end
      if (dropped) begin
         i = 0;
         while (i + 1 < shadow_count) begin
            if (shadow_style[i] == shadow_style[i+1]) begin
               shadow_len[i] += shadow_len[i+1];
               slot_close(i + 1);
            end else begin
               i++;
            end
         end
      end
   endfunction

   // applies one operation to the shadow table and returns the expected response
   function automatic span_result_type predict_span_op(rlst_pkg::kind_type k,
                                                       longint unsigned off,
                                                       logic [STYLE_BITS-1:0] st,
                                                       longint unsigned ln);
      span_result_type r;
      longint unsigned start;
      int unsigned pick;
      r = '{acc: 1'b1, fv: 1'b0, fs: '0, fl: '0, runs: '0, total: '0};
      case (k)
         rlst_pkg::KIND_INSERT: r.acc = span_insert(off, st, ln);
         rlst_pkg::KIND_REMOVE: range_remove(off, ln);
         rlst_pkg::KIND_FIND: begin
            if (shadow_count > 0) begin
               start = 0;
               pick = shadow_count - 1;
               for (int unsigned i = 0; i < shadow_count; i++) begin
                  start += shadow_len[i];
                  if (start > off) begin
                     pick = i;
                     break;
                  end
               end
               r.fv = 1'b1;
               r.fs = shadow_style[pick];
               r.fl = LENGTH_BITS'(shadow_len[pick]);
            end
         end
         default: shadow_count = 0;
      endcase
      r.runs  = CNT_BITS'(shadow_count);
      r.total = LENGTH_BITS'(table_sum());
      return r;
   endfunction

   // directed rows: extremes, every operation, refusals, splits, merges
   stim_row_type dir_rows [] = '{
      '{rlst_pkg::KIND_FIND,   16'd0,    8'd0,  16'd0,    1'b1, 1'b1, 7'd0, 16'd0},  // find on empty
      '{rlst_pkg::KIND_REMOVE, 16'd0,    8'd0,  16'd5,    1'b1, 1'b1, 7'd0, 16'd0},  // remove on empty
      '{rlst_pkg::KIND_INSERT, 16'd0,    8'd1,  16'd0,    1'b1, 1'b1, 7'd1, 16'd0},  // empty run
      '{rlst_pkg::KIND_INSERT, 16'd0,    8'd1,  16'd10,   1'b1, 1'b1, 7'd1, 16'd10}, // extend same style
      '{rlst_pkg::KIND_INSERT, 16'd5,    8'd2,  16'd4,    1'b0, 1'b0, 7'd0, 16'd0},  // split in three
      '{rlst_pkg::KIND_INSERT, 16'd0,    8'd3,  16'd3,    1'b0, 1'b0, 7'd0, 16'd0},  // before first
      '{rlst_pkg::KIND_INSERT, 16'hffff, 8'hff, 16'd2,    1'b0, 1'b0, 7'd0, 16'd0},  // past the end
      '{rlst_pkg::KIND_INSERT, 16'd3,    8'd1,  16'hffff, 1'b1, 1'b0, 7'd5, 16'd19}, // overflow refused
      '{rlst_pkg::KIND_FIND,   16'd4,    8'd0,  16'd0,    1'b0, 1'b0, 7'd0, 16'd0},
      '{rlst_pkg::KIND_FIND,   16'hffff, 8'd0,  16'd0,    1'b0, 1'b0, 7'd0, 16'd0},  // find past end
      '{rlst_pkg::KIND_REMOVE, 16'd8,    8'd0,  16'd4,    1'b0, 1'b0, 7'd0, 16'd0},  // drop run, merge
      '{rlst_pkg::KIND_REMOVE, 16'd2,    8'd0,  16'd0,    1'b0, 1'b0, 7'd0, 16'd0},  // zero length
      '{rlst_pkg::KIND_REMOVE, 16'hffff, 8'd0,  16'hffff, 1'b0, 1'b0, 7'd0, 16'd0},
      '{rlst_pkg::KIND_REMOVE, 16'd1,    8'd0,  16'd3,    1'b0, 1'b0, 7'd0, 16'd0},
      '{rlst_pkg::KIND_CLEAR,  16'hffff, 8'hff, 16'hffff, 1'b1, 1'b1, 7'd0, 16'd0},
      '{rlst_pkg::KIND_INSERT, 16'd0,    8'haa, 16'hffff, 1'b1, 1'b1, 7'd1, 16'hffff}, // max total
      '{rlst_pkg::KIND_INSERT, 16'd7,    8'h55, 16'd1,    1'b1, 1'b0, 7'd1, 16'hffff}, // overflow
      '{rlst_pkg::KIND_INSERT, 16'd7,    8'h55, 16'd0,    1'b0, 1'b0, 7'd0, 16'd0},
      '{rlst_pkg::KIND_REMOVE, 16'd0,    8'd0,  16'hffff, 1'b0, 1'b0, 7'd0, 16'd0},
      '{rlst_pkg::KIND_CLEAR,  16'd0,    8'd0,  16'd0,    1'b1, 1'b1, 7'd0, 16'd0}
   };

   // one transaction: bursts of valid with random gaps between them
   int burst_left = 0;
   task automatic send_op(rlst_pkg::kind_type k, logic [LENGTH_BITS-1:0] off,
                          logic [STYLE_BITS-1:0] st, logic [LENGTH_BITS-1:0] ln);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_kind        <= k;
      req_text_offset <= off;
      req_run_style   <= st;
      req_span_length <= ln;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // prediction is made at acceptance so the queue stays in transaction order
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_results.push_back(predict_span_op(rlst_pkg::kind_type'(req_kind),
                                                    req_text_offset, req_run_style,
                                                    req_span_length));
   end

   // receiver stall pattern: alternating stall and flow windows
   int rx_phase = 0;
   always @(negedge clock) begin
      rx_phase++;
      if (rx_phase % 200 < 60)       rsp_ready <= 1'b1;
      else if (rx_phase % 200 < 120) rsp_ready <= ($urandom_range(0, 3) != 0);
      else                           rsp_ready <= ($urandom_range(0, 2) == 0);
   end

   task automatic report_field(string name, longint unsigned exp_v, longint unsigned act_v);
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      span_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected response, none pending", $time);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_accepted !== e.acc) report_field("accepted", e.acc, rsp_accepted);
            if (rsp_found_valid !== e.fv) report_field("found_valid", e.fv, rsp_found_valid);
            if (rsp_found_style !== e.fs) report_field("found_style", e.fs, rsp_found_style);
            if (rsp_found_length !== e.fl) report_field("found_length", e.fl, rsp_found_length);
            if (rsp_runs_in_use !== e.runs) report_field("runs_in_use", e.runs, rsp_runs_in_use);
            if (rsp_total_text_length !== e.total)
               report_field("total_text_length", e.total, rsp_total_text_length);
         end
      end
   end

   // random offset mostly within the text so splits and removes land on runs
   function automatic logic [LENGTH_BITS-1:0] pick_offset();
      longint unsigned t;
      t = table_sum();
      case ($urandom_range(0, 9))
         0: return LENGTH_BITS'($urandom_range(0, LMAX));
         1: return LENGTH_BITS'(t);
         default: return (t == 0) ? '0 : LENGTH_BITS'($urandom_range(0, 32'(t)));
      endcase
   endfunction

   initial begin
      rlst_pkg::kind_type k;
      int sel;
      int cap;
      shadow_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         // typed-in expectations are checked against the predictor's view
         send_op(dir_rows[i].kind, dir_rows[i].off, dir_rows[i].style, dir_rows[i].len);
         if (dir_rows[i].fixed) begin
            span_result_type p;
            p = expected_results[$];
            if (p.acc !== dir_rows[i].acc || p.runs !== dir_rows[i].runs ||
                p.total !== dir_rows[i].total) begin
               $display("%0t mismatch directed row %0d: expected %0h/%0d/%0h actual %0h/%0d/%0h",
                        $time, i, dir_rows[i].acc, dir_rows[i].runs, dir_rows[i].total,
                        p.acc, p.runs, p.total);
               fail_count++;
            end
         end
      end

      // random phase; style cap varies so runs both merge often and stay distinct,
      // and lengths stay small so the table fills to its limit
      for (int n = 0; n < 750; n++) begin
         if (n % 150 == 0) cap = (n % 300 == 0) ? 3 : 255;
         sel = $urandom_range(0, 99);
         if (sel < 55)      k = rlst_pkg::KIND_INSERT;
         else if (sel < 75) k = rlst_pkg::KIND_REMOVE;
         else if (sel < 98) k = rlst_pkg::KIND_FIND;
         else               k = rlst_pkg::KIND_CLEAR;
         send_op(k, pick_offset(),
                 STYLE_BITS'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, cap)),
                 LENGTH_BITS'(($urandom_range(0, 29) == 0) ? $urandom_range(0, LMAX)
                                                           : $urandom_range(0, 40)));
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // time limit for 770 transactions with their gaps and stalls, several times over
   initial begin
      #(12 * 1000000);
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
